>>> sv/b64e_pkg.sv
// b64e_pkg: shared types, constants and the digit-to-ASCII map for the base64 stream encoder.
// Uses nothing else. Used by b64e_pack, b64e_emit, base64_stream_encoder and b64e_checker.
package b64e_pkg;

  localparam logic [7:0] CHAR_PAD       = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER_OFS = 8'd71;  // 'a' - 26
  localparam logic [7:0] CHAR_DIGIT_OFS = 8'd4;   // 52 - '0'
  localparam logic [7:0] CHAR_STD_62    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_STD_63    = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_ALT_62    = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ALT_63    = 8'h7E;  // '~'

  localparam logic [5:0] DIGIT_LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_NUM_BASE   = 6'd52;
  localparam logic [5:0] DIGIT_62         = 6'd62;

  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2,
    PHASE_X = 2'd3
  } phase_t;

  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  // one item's worth of output symbols
  typedef struct packed {
    logic           last;
    logic [1:0]     count_m1;
    sym_t [3:0]     sym;
  } grp_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic std_mode);
    logic [7:0] dx;
    dx = {2'b00, d};
    if (d < DIGIT_LOWER_BASE) begin
      return CHAR_UPPER_A + dx;
    end else if (d < DIGIT_NUM_BASE) begin
      return CHAR_LOWER_OFS + dx;
    end else if (d < DIGIT_62) begin
      return dx - CHAR_DIGIT_OFS;
    end else if (d == DIGIT_62) begin
      return std_mode ? CHAR_STD_62 : CHAR_ALT_62;
    end else begin
      return std_mode ? CHAR_STD_63 : CHAR_ALT_63;
    end
  endfunction

  function automatic logic [7:0] sym_char(input sym_t s, input logic std_mode);
    return s.pad ? CHAR_PAD : digit_char(s.val, std_mode);
  endfunction

endpackage

>>> sv/b64e_byte_if.sv
// b64e_byte_if: valid/ready channel that carries one message byte and its last mark.
// Depends on nothing.
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/b64e_char_if.sv
// b64e_char_if: valid/ready channel that carries one encoded character and its last mark.
// Depends on nothing.
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

>>> sv/base64_stream_encoder.sv
// base64_stream_encoder: top level of the streaming base64 encoder.
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if, b64e_pack and b64e_emit.
//
//   port  | dir | item                          | handshake
//   ------+-----+-------------------------------+------------
//   msg   | in  | data_byte[7:0], last_byte     | valid/ready
//   enc   | out | out_char[7:0], last_char      | valid/ready
//   cfg   | in  | cfg_wdata = alphabet mode     | cfg_we
//
// A byte yields 1 to 4 characters. The output runs at one character per cycle unless enc
// stalls; the next byte is taken in the cycle the final character of its predecessor is
// registered. A byte passes the group register in b64e_pack, then the output register in
// b64e_emit. Synchronous reset clears phase, leftover bits, mode and all valid flags. A
// stall on enc backs up to msg.
module base64_stream_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  b64e_byte_if.sink   msg,
  b64e_char_if.source enc
);
  import b64e_pkg::*;

  logic grp_valid;
  grp_t grp;
  logic grp_done;

  b64e_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_done  (grp_done)
  );

  b64e_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_done  (grp_done),
    .enc       (enc)
  );

endmodule

>>> sv/b64e_pack.sv
// b64e_pack: takes message bytes, keeps group phase and leftover bits, and registers
// the 1 to 4 output symbols of each item. Depends on b64e_pkg and b64e_byte_if.
module b64e_pack (
  input  logic           clk,
  input  logic           rst,
  b64e_byte_if.sink      msg,
  output logic           grp_valid,
  output b64e_pkg::grp_t grp,
  input  logic           grp_done
);
  import b64e_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] leftover, leftover_next;
  grp_t       grp_next;
  logic       accept;

  assign msg.ready = !grp_valid || grp_done;
  assign accept    = msg.valid && msg.ready;

  always_comb begin
    logic [7:0] b;
    logic       fin;
    b             = msg.data_byte;
    fin           = msg.last_byte;
    grp_next      = '0;
    grp_next.last = fin;
    phase_next    = PHASE_0;
    leftover_next = 4'd0;
    case (phase)
      PHASE_1: begin
        grp_next.sym[0].val = {leftover[1:0], b[7:4]};
        if (fin) begin
          grp_next.sym[1].val = {b[3:0], 2'b00};
          grp_next.sym[2].pad = 1'b1;
          grp_next.count_m1   = 2'd2;
        end else begin
          phase_next    = PHASE_2;
          leftover_next = b[3:0];
        end
      end
      PHASE_2: begin
        grp_next.sym[0].val = {leftover, b[7:6]};
        grp_next.sym[1].val = b[5:0];
        grp_next.count_m1   = 2'd1;
      end
      default: begin
        grp_next.sym[0].val = b[7:2];
        if (fin) begin
          grp_next.sym[1].val = {b[1:0], 4'd0};
          grp_next.sym[2].pad = 1'b1;
          grp_next.sym[3].pad = 1'b1;
          grp_next.count_m1   = 2'd3;
        end else begin
          phase_next    = PHASE_1;
          leftover_next = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      phase     <= PHASE_0;
      leftover  <= 4'd0;
    end else if (accept) begin
      grp_valid <= 1'b1;
      phase     <= phase_next;
      leftover  <= leftover_next;
    end else if (grp_done) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp <= grp_next;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (rst) phase != PHASE_X)
    else $error("group phase reached unused code");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
      accept && msg.last_byte |=> phase == PHASE_0 && leftover == 4'd0)
    else $error("state not cleared after last byte");
  a_done_needs_grp: assert property (@(posedge clk) disable iff (rst) grp_done |-> grp_valid)
    else $error("group done without a group held");

endmodule

>>> sv/b64e_emit.sv
// b64e_emit: holds the alphabet mode, walks the held symbols one per cycle unless enc
// stalls and maps them to ASCII into the output register. Uses b64e_pkg, b64e_char_if.
module b64e_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           grp_valid,
  input  b64e_pkg::grp_t grp,
  output logic           grp_done,
  b64e_char_if.source    enc
);
  import b64e_pkg::*;

  logic       mode;
  logic [1:0] idx;
  logic       step;
  logic       at_end;

  assign step     = grp_valid && (!enc.valid || enc.ready);
  assign at_end   = idx == grp.count_m1;
  assign grp_done = step && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      idx       <= 2'd0;
      enc.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (step) begin
        idx       <= at_end ? 2'd0 : idx + 2'd1;
        enc.valid <= 1'b1;
      end else if (enc.ready) begin
        enc.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      enc.out_char  <= sym_char(grp.sym[idx], mode);
      enc.last_char <= grp.last && at_end;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
      grp_valid |-> idx <= grp.count_m1)
    else $error("symbol index past group count");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst) !grp_valid |-> idx == 2'd0)
    else $error("symbol index not reset between groups");
  a_last_out: assert property (@(posedge clk) disable iff (rst)
      grp_done && grp.last |=> enc.valid && enc.last_char)
    else $error("final character not marked");

endmodule

>>> dv/b64e_checker.sv
`timescale 1ns / 1ps
// b64e_checker: watches the byte and character channels of the base64 stream encoder,
// predicts the characters of each accepted item and compares them in order.
// Depends on b64e_pkg, b64e_byte_if and b64e_char_if.
module b64e_checker (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  input  logic  done,
  b64e_byte_if  msg,
  b64e_char_if  enc,
  output int    fail_count,
  output int    pending
);
  import b64e_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  enc_char_t  chars_due[$];
  phase_t     enc_phase;
  logic [3:0] enc_leftover;
  logic       std_alphabet;
  logic       done_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    enc_phase    = PHASE_0;
    enc_leftover = '0;
    std_alphabet = 1'b0;
    done_seen    = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  function automatic logic [7:0] b64_char(input logic [5:0] d);
    logic [7:0] dw;
    dw = {2'b00, d};
    if (dw < 8'd26) begin
      return 8'h41 + dw;
    end else if (dw < 8'd52) begin
      return 8'h61 + (dw - 8'd26);
    end else if (dw < 8'd62) begin
      return 8'h30 + (dw - 8'd52);
    end else if (dw == 8'd62) begin
      return std_alphabet ? CHAR_STD_62 : CHAR_ALT_62;
    end
    return std_alphabet ? CHAR_STD_63 : CHAR_ALT_63;
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic fin);
    enc_char_t e;
    e.ch  = ch;
    e.fin = fin;
    chars_due = {chars_due, e};
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (enc_phase)
      PHASE_1: begin
        push_char(b64_char({enc_leftover[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(b64_char({b[3:0], 2'b00}), 1'b0);
          push_char(CHAR_PAD, 1'b1);
          enc_phase    = PHASE_0;
          enc_leftover = '0;
        end else begin
          enc_phase    = PHASE_2;
          enc_leftover = b[3:0];
        end
      end
      PHASE_2: begin
        push_char(b64_char({enc_leftover, b[7:6]}), 1'b0);
        push_char(b64_char(b[5:0]), fin);
        enc_phase    = PHASE_0;
        enc_leftover = '0;
      end
      default: begin
        push_char(b64_char(b[7:2]), 1'b0);
        if (fin) begin
          push_char(b64_char({b[1:0], 4'b0000}), 1'b0);
          push_char(CHAR_PAD, 1'b0);
          push_char(CHAR_PAD, 1'b1);
          enc_phase    = PHASE_0;
          enc_leftover = '0;
        end else begin
          enc_phase    = PHASE_1;
          enc_leftover = {2'b00, b[1:0]};
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    enc_char_t e;
    if (rst) begin
      chars_due.delete();
      enc_phase    = PHASE_0;
      enc_leftover = '0;
      std_alphabet = 1'b0;
    end else begin
      if (enc.valid && enc.ready) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    enc.out_char, enc.last_char));
        end else begin
          e = chars_due.pop_front();
          if (enc.out_char !== e.ch) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      enc.out_char, e.ch));
          end
          if (enc.last_char !== e.fin) begin
            report_mismatch($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                                      enc.last_char, e.fin, e.ch));
          end
        end
      end
      if (msg.valid && msg.ready) begin
        encode_byte(msg.data_byte, msg.last_byte);
      end
      if (cfg_we) begin
        std_alphabet = cfg_wdata;
      end
      if (done && !done_seen) begin
        done_seen = 1'b1;
        foreach (chars_due[i]) begin
          report_mismatch($sformatf("char 0x%02h last=%0b never arrived",
                                    chars_due[i].ch, chars_due[i].fin));
        end
      end
    end
    pending = chars_due.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for base64_stream_encoder; directed messages on both
// alphabets, then random messages with random idling on both channels.
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if, the encoder RTL and b64e_checker.
module tb_top;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic done;
  logic calm;
  int   fail_count;
  int   pending;
  int   items_sent;

  b64e_byte_if msg_if ();
  b64e_char_if enc_if ();

  base64_stream_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .msg       (msg_if),
    .enc       (enc_if)
  );

  b64e_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .msg        (msg_if),
    .enc        (enc_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    done             = 1'b0;
    calm             = 1'b0;
    items_sent       = 0;
    msg_if.valid     = 1'b0;
    msg_if.data_byte = '0;
    msg_if.last_byte = 1'b0;
    enc_if.ready     = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic logic stall_now();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  always @(posedge clk) begin
    enc_if.ready <= !stall_now();
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (stall_now()) begin
      msg_if.valid     <= 1'b0;
      msg_if.data_byte <= 8'($urandom);
      msg_if.last_byte <= 1'($urandom);
      @(posedge clk);
    end
    msg_if.valid     <= 1'b1;
    msg_if.data_byte <= b;
    msg_if.last_byte <= fin;
    do @(posedge clk); while (!msg_if.ready);
    items_sent++;
  endtask

  task automatic drain();
    msg_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_alphabet(input logic std);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= std;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_group(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2);
    send_byte(b0, 1'b0);
    send_byte(b1, 1'b0);
    send_byte(b2, 1'b1);
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, alternate alphabet from reset
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFB, 1'b1);
    send_group(8'hFB, 8'hEF, 8'hBE);
    send_group(8'hFF, 8'hFF, 8'hFF);
    // alphabet switch in the middle of a message
    send_byte(8'h00, 1'b0);
    set_alphabet(1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_group(8'hFB, 8'hEF, 8'hBE);
    send_group(8'hFF, 8'hFF, 8'hFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    set_alphabet(1'b0);

    // random messages
    while (items_sent < 230) begin
      calm = (items_sent >= 110) && (items_sent < 170);
      len  = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int i = 1; i <= len; i++) begin
        send_byte(8'($urandom), i == len);
      end
      if ($urandom_range(5) == 0) begin
        set_alphabet(1'($urandom));
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
